>>> rtl/core/zad_pkg.sv
// shared constants and types of the z-score anomaly detector
package zad_pkg;

  localparam int unsigned THR_W     = 16;
  localparam int unsigned T2_W      = 2 * THR_W;
  localparam int unsigned Q_SHIFT   = 16;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [THR_W-1:0] THR_RESET = 16'd768;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } zad_status_e;

endpackage

>>> rtl/core/zad_ram.sv
// generic single-write single-read ram with registered read data
module zad_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/zad_fifo.sv
// short job queue between the sample loader and the compute engine
module zad_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/zad_front.sv
// sample loader: stores samples, keeps count, sum and overflow, issues block jobs
module zad_front #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                      sample_i,
  input  logic                                        last_i,
  input  logic                                        hold_i,
  output logic                                        we_o,
  output logic [(MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1)-1:0] waddr_o,
  output logic [SAMPLE_BITS-1:0]                      wdata_o,
  output logic                                        push_o,
  output logic [$clog2(MAX_SAMPLES + 1)-1:0]          job_cnt_o,
  output logic [SAMPLE_BITS + $clog2(MAX_SAMPLES + 1)-1:0] job_sum_o,
  output logic                                        job_ovf_o
);

  localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = SAMPLE_BITS + CW;

  logic [CW-1:0]   cnt_q, cnt_d, cnt_n;
  logic [SUMW-1:0] sum_q, sum_d, sum_n;
  logic            ovf_q, ovf_d, ovf_n;
  logic            accept, room;
  logic [SUMW-1:0] sample_ext;

  assign in_ready_o = !hold_i;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CW'(MAX_SAMPLES));
  assign sample_ext = {{(SUMW - SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};

  assign cnt_n = room ? cnt_q + CW'(1) : cnt_q;
  assign sum_n = room ? sum_q + sample_ext : sum_q;
  assign ovf_n = ovf_q || !room;

  assign we_o    = accept && room;
  assign waddr_o = cnt_q[AW-1:0];
  assign wdata_o = sample_i;

  assign push_o    = accept && last_i;
  assign job_cnt_o = cnt_n;
  assign job_sum_o = sum_n;
  assign job_ovf_o = ovf_n;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
        sum_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_n;
        sum_d = sum_n;
        ovf_d = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

>>> rtl/core/zad_back.sv
// compute engine: spread pass, threshold product, check pass and result register
module zad_back #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        job_valid_i,
  output logic                                        job_pop_o,
  input  logic [$clog2(MAX_SAMPLES + 1)-1:0]          job_cnt_i,
  input  logic [SAMPLE_BITS + $clog2(MAX_SAMPLES + 1)-1:0] job_sum_i,
  input  logic                                        job_ovf_i,
  input  logic [zad_pkg::THR_W-1:0]                   thr_i,
  output logic                                        busy_o,
  output logic                                        re_o,
  output logic [(MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1)-1:0] raddr_o,
  input  logic [SAMPLE_BITS-1:0]                      rdata_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [zad_pkg::OUT_IDX_W-1:0]               sample_index_o,
  output logic                                        found_o,
  output logic                                        last_result_o,
  output logic [1:0]                                  status_o
);

  localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW   = SAMPLE_BITS;
  localparam int unsigned SUMW = SW + CW;
  localparam int unsigned DW   = SW + CW + 1;
  localparam int unsigned MAGW = SW + CW;
  localparam int unsigned SQW  = 2 * MAGW;
  localparam int unsigned SPW  = SQW + CW;
  localparam int unsigned LW   = SQW + CW;
  localparam int unsigned HALF = (SPW + 1) / 2;
  localparam int unsigned PW   = zad_pkg::T2_W + HALF;
  localparam int unsigned RHSW = zad_pkg::T2_W + 2 * HALF;
  localparam int unsigned IXW  = (AW > zad_pkg::OUT_IDX_W) ? AW : zad_pkg::OUT_IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPREAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RHS,
    ST_CHECK,
    ST_FIN
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          n_q;
  logic [SUMW-1:0]        sum_q;
  zad_pkg::zad_status_e   status_q;
  logic [zad_pkg::T2_W-1:0] t2_q;
  logic [SPW-1:0]         spread_q;
  logic [PW-1:0]          plo_q, phi_q;
  logic [RHSW-1:0]        rhs_q;
  logic                   issue_q;
  logic [AW-1:0]          idx_q;

  logic                   v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0]          i1_q, i2_q, i3_q, i4_q;
  logic [MAGW-1:0]        mag_q;
  logic [SQW-1:0]         sq_q;
  logic [LW-1:0]          l_q;
  logic                   pend_v_q;
  logic [AW-1:0]          pend_i_q;

  logic                   out_valid_q;
  logic [zad_pkg::OUT_IDX_W-1:0] out_idx_q;
  logic                   out_found_q, out_last_q;
  logic [1:0]             out_status_q;

  logic                   in_pass, out_free, flag, emit, adv, issue, drained, last_issue;
  logic [DW-1:0]          n_ext, x_ext, s_ext, dev, dev_abs;
  logic [2*HALF-1:0]      spread_pad;
  logic [RHSW-1:0]        lhs;
  logic [IXW-1:0]         pend_ix_ext;

  logic                        push_out;
  logic [zad_pkg::OUT_IDX_W-1:0] push_idx;
  logic                        push_found, push_last;

  assign in_pass  = (state_q == ST_SPREAD) || (state_q == ST_CHECK);
  assign out_free = !out_valid_q || out_ready_i;
  assign lhs      = RHSW'(l_q) << zad_pkg::Q_SHIFT;
  assign flag     = v4_q && (lhs > rhs_q);
  assign emit     = flag && pend_v_q;
  assign adv      = !(emit && !out_free);
  assign issue    = in_pass && issue_q && adv;
  assign drained  = !issue_q && !v1_q && !v2_q && !v3_q && !v4_q;
  assign last_issue = (CW'(idx_q) == n_q - CW'(1));

  assign re_o    = adv;
  assign raddr_o = idx_q;
  assign busy_o  = (state_q != ST_IDLE);
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  // deviation of one sample: n*x - sum
  assign n_ext   = DW'(n_q);
  assign x_ext   = {{(DW - SW){rdata_i[SW-1]}}, rdata_i};
  assign s_ext   = {{(DW - SUMW){sum_q[SUMW-1]}}, sum_q};
  assign dev     = n_ext * x_ext - s_ext;
  assign dev_abs = dev[DW-1] ? (~dev + DW'(1)) : dev;

  assign spread_pad  = (2 * HALF)'(spread_q);
  assign pend_ix_ext = IXW'(pend_i_q);

  always_comb begin
    push_out   = 1'b0;
    push_idx   = '0;
    push_found = 1'b0;
    push_last  = 1'b0;
    if (state_q == ST_CHECK && emit && adv) begin
      push_out   = 1'b1;
      push_idx   = pend_ix_ext[zad_pkg::OUT_IDX_W-1:0];
      push_found = 1'b1;
    end else if (state_q == ST_FIN && out_free) begin
      push_out   = 1'b1;
      push_last  = 1'b1;
      push_found = pend_v_q;
      push_idx   = pend_v_q ? pend_ix_ext[zad_pkg::OUT_IDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q && (state_q == ST_CHECK);
      end

      if (issue) begin
        idx_q <= idx_q + AW'(1);
        if (last_issue) begin
          issue_q <= 1'b0;
        end
      end

      if (state_q == ST_CHECK && adv && flag) begin
        pend_v_q <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            pend_v_q <= 1'b0;
            if (job_cnt_i < CW'(2)) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_SPREAD;
              idx_q   <= '0;
              issue_q <= 1'b1;
            end
          end
        end
        ST_SPREAD: begin
          if (drained) begin
            state_q <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: state_q <= ST_MUL_HI;
        ST_MUL_HI: state_q <= ST_RHS;
        ST_RHS: begin
          state_q <= ST_CHECK;
          idx_q   <= '0;
          issue_q <= 1'b1;
        end
        ST_CHECK: begin
          if (drained) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      n_q   <= job_cnt_i;
      sum_q <= job_sum_i;
      t2_q  <= zad_pkg::T2_W'(thr_i) * zad_pkg::T2_W'(thr_i);
      spread_q <= '0;
      if (job_cnt_i < CW'(2)) begin
        status_q <= zad_pkg::STATUS_SHORT;
      end else if (job_ovf_i) begin
        status_q <= zad_pkg::STATUS_OVERFLOW;
      end else begin
        status_q <= zad_pkg::STATUS_OK;
      end
    end

    if (adv) begin
      i1_q  <= idx_q;
      i2_q  <= i1_q;
      mag_q <= dev_abs[MAGW-1:0];
      i3_q  <= i2_q;
      sq_q  <= SQW'(mag_q) * SQW'(mag_q);
      i4_q  <= i3_q;
      l_q   <= LW'(n_q) * LW'(sq_q);
    end

    if (state_q == ST_SPREAD && v3_q) begin
      spread_q <= spread_q + SPW'(sq_q);
    end

    if (state_q == ST_MUL_LO) begin
      plo_q <= PW'(t2_q) * PW'(spread_pad[HALF-1:0]);
    end
    if (state_q == ST_MUL_HI) begin
      phi_q <= PW'(t2_q) * PW'(spread_pad[2*HALF-1:HALF]);
    end
    if (state_q == ST_RHS) begin
      rhs_q <= RHSW'(plo_q) + (RHSW'(phi_q) << HALF);
    end

    if (state_q == ST_CHECK && adv && flag) begin
      pend_i_q <= i4_q;
    end

    if (push_out) begin
      out_idx_q    <= push_idx;
      out_found_q  <= push_found;
      out_last_q   <= push_last;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_index_o = out_idx_q;
  assign found_o        = out_found_q;
  assign last_result_o  = out_last_q;
  assign status_o       = out_status_q;

endmodule

>>> rtl/core/zscore_anomaly_detector_core.sv
// z-score anomaly detector top level: config register, loader, job queue, ram, compute engine
// samples load at one beat per cycle unless input is held off; the beat with last
// closes the block; a block of n >= 2 samples is checked in two passes over the sample
// ram, a spread pass and a check pass, at one read per cycle unless the result output
// stalls; input is held off after last until the engine hands over the final result
// reset clears counters, queue and engine and sets the threshold to 3.0; no ram clearing
module zscore_anomaly_detector_core #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [zad_pkg::APB_AW-1:0]       paddr,
  input  logic [zad_pkg::APB_DW-1:0]       pwdata,
  output logic [zad_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [zad_pkg::OUT_IDX_W-1:0]    sample_index_o,
  output logic                             found_o,
  output logic                             last_result_o,
  output logic [1:0]                       status_o
);

  localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = SAMPLE_BITS + CW;
  localparam int unsigned JW   = CW + SUMW + 1;

  logic [zad_pkg::THR_W-1:0] thr_q;
  logic                      cfg_wr, cfg_hit;

  logic                   we, re, push, pop, q_empty, q_full, busy, hold, job_ovf;
  logic [AW-1:0]          waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;
  logic [CW-1:0]          job_cnt, q_cnt;
  logic [SUMW-1:0]        job_sum, q_sum;
  logic                   q_ovf;
  logic [JW-1:0]          q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == zad_pkg::REG_THRESHOLD);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? zad_pkg::APB_DW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= zad_pkg::THR_RESET;
    end else if (cfg_wr) begin
      thr_q <= pwdata[zad_pkg::THR_W-1:0];
    end
  end

  assign hold = !q_empty || busy;

  zad_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .last_i    (last_i),
    .hold_i    (hold),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .push_o    (push),
    .job_cnt_o (job_cnt),
    .job_sum_o (job_sum),
    .job_ovf_o (job_ovf)
  );

  assign q_wdata = {job_cnt, job_sum, job_ovf};
  assign {q_cnt, q_sum, q_ovf} = q_rdata;

  zad_fifo #(
    .WIDTH(JW),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  zad_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  zad_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!q_empty),
    .job_pop_o     (pop),
    .job_cnt_i     (q_cnt),
    .job_sum_i     (q_sum),
    .job_ovf_i     (q_ovf),
    .thr_i         (thr_q),
    .busy_o        (busy),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_index_o(sample_index_o),
    .found_o       (found_o),
    .last_result_o (last_result_o),
    .status_o      (status_o)
  );

  // no sample beat is taken while the engine reads the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !busy)
    else $error("sample beat accepted while engine busy");

  // the queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue overflow");

  // a result without an anomaly always closes its block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> last_result_o)
    else $error("end marker not final");

  // a short block reports nothing found at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == 2'(zad_pkg::STATUS_SHORT)))
      |-> (!found_o && (sample_index_o == '0)))
    else $error("short block result malformed");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the z-score anomaly detector core
module testbench;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [zad_pkg::OUT_IDX_W-1:0] sample_index;
    logic                          found;
    logic                          last_result;
    zad_pkg::zad_status_e          status;
  } outcome_t;

  localparam int unsigned     STORE_DEPTH    = 64;
  localparam int unsigned     SETTLE_CYCLES  = 200;
  localparam int unsigned     WATCHDOG_LIMIT = 4000;
  localparam logic [zad_pkg::APB_AW-1:0] THR_ADDR = {zad_pkg::REG_THRESHOLD, 2'b00};

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [zad_pkg::APB_AW-1:0]    paddr          = '0;
  logic [zad_pkg::APB_DW-1:0]    pwdata         = '0;
  logic [zad_pkg::APB_DW-1:0]    prdata;
  logic                          pready;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [15:0]                   sample_i       = '0;
  logic                          last_i         = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [zad_pkg::OUT_IDX_W-1:0] sample_index_o;
  logic                          found_o;
  logic                          last_result_o;
  logic [1:0]                    status_o;

  zscore_anomaly_detector_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_index_o (sample_index_o),
    .found_o        (found_o),
    .last_result_o  (last_result_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  beat_t    beat_queue[$];
  outcome_t hit_queue[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       fail_count    = 0;
  int       beats_queued  = 0;
  int       idle_cycles   = 0;
  beat_t    next_beat;

  // block model state
  logic signed [15:0] blk_store[STORE_DEPTH];
  int                 blk_count = 0;
  longint             blk_sum   = 0;
  logic               blk_ovf   = 1'b0;
  logic [15:0]        blk_thr   = zad_pkg::THR_RESET;

  function automatic logic [127:0] dev_square(int idx);
    longint d;
    d = longint'(blk_count) * longint'(blk_store[idx]) - blk_sum;
    if (d < 0) d = -d;
    return 128'(d * d);
  endfunction

  task automatic absorb_sample(logic signed [15:0] x, logic lst);
    outcome_t    found_list[$];
    outcome_t    o;
    logic [127:0] spread;
    logic [127:0] rhs;
    logic [127:0] lhs;
    zad_pkg::zad_status_e st;
    if (blk_count < STORE_DEPTH) begin
      blk_store[blk_count] = x;
      blk_count++;
      blk_sum += longint'(x);
    end else begin
      blk_ovf = 1'b1;
    end
    if (lst) begin
      if (blk_count < 2) begin
        o = '{sample_index: '0, found: 1'b0, last_result: 1'b1,
              status: zad_pkg::STATUS_SHORT};
        found_list = {found_list, o};
      end else begin
        st = blk_ovf ? zad_pkg::STATUS_OVERFLOW : zad_pkg::STATUS_OK;
        spread = '0;
        for (int i = 0; i < blk_count; i++) spread += dev_square(i);
        rhs = 128'(blk_thr) * 128'(blk_thr) * spread;
        for (int i = 0; i < blk_count; i++) begin
          lhs = (128'(blk_count) * dev_square(i)) << zad_pkg::Q_SHIFT;
          if (lhs > rhs) begin
            o = '{sample_index: zad_pkg::OUT_IDX_W'(i), found: 1'b1, last_result: 1'b0,
                  status: st};
            found_list = {found_list, o};
          end
        end
        if (found_list.size() == 0) begin
          o = '{sample_index: '0, found: 1'b0, last_result: 1'b1, status: st};
          found_list = {found_list, o};
        end else begin
          found_list[found_list.size()-1].last_result = 1'b1;
        end
      end
      foreach (found_list[i]) hit_queue = {hit_queue, found_list[i]};
      blk_count = 0;
      blk_sum   = 0;
      blk_ovf   = 1'b0;
    end
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) absorb_sample(sample_i, last_i);
      if (beat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beat_queue.pop_front();
        in_valid_i <= 1'b1;
        sample_i   <= next_beat.sample;
        last_i     <= next_beat.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (hit_queue.size() == 0) begin
          $error("result beat with nothing expected: index %0d found %0b",
                 sample_index_o, found_o);
          fail_count++;
        end else begin
          automatic outcome_t exp_o = hit_queue.pop_front();
          if (sample_index_o !== exp_o.sample_index) begin
            $error("sample_index: expected %0d, actual %0d", exp_o.sample_index, sample_index_o);
            fail_count++;
          end
          if (found_o !== exp_o.found) begin
            $error("found: expected %0b, actual %0b", exp_o.found, found_o);
            fail_count++;
          end
          if (last_result_o !== exp_o.last_result) begin
            $error("last_result: expected %0b, actual %0b", exp_o.last_result, last_result_o);
            fail_count++;
          end
          if (status_o !== exp_o.status) begin
            $error("status: expected %0d, actual %0d", exp_o.status, status_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_beat(int value, logic lst);
    beat_t b;
    b.sample = 16'(value);
    b.last   = lst;
    beat_queue = {beat_queue, b};
    beats_queued++;
  endtask

  task automatic push_block(int n, bit clustered);
    int base;
    int spread;
    int v;
    base   = int'($urandom_range(40000)) - 20000;
    spread = int'($urandom_range(300));
    for (int i = 0; i < n; i++) begin
      if (!clustered || $urandom_range(9) == 0) v = int'($urandom);
      else v = base + int'($urandom_range(2 * spread)) - spread;
      push_beat(v, i == n - 1);
    end
  endtask

  task automatic fill_random(int quota);
    int start;
    int r;
    int n;
    start = beats_queued;
    while (beats_queued - start < quota) begin
      r = $urandom_range(99);
      if (r < 5)       n = 1;
      else if (r < 80) n = $urandom_range(12, 2);
      else if (r < 95) n = $urandom_range(40, 13);
      else             n = $urandom_range(64, 41);
      push_block(n, $urandom_range(3) != 0);
    end
  endtask

  task automatic drain_and_settle();
    while (beat_queue.size() > 0 || in_valid_i || hit_queue.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THR_ADDR;
    pwdata  <= zad_pkg::APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    blk_thr = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== zad_pkg::APB_DW'(value)) begin
      $error("threshold readback: expected %0d, actual %0d", value, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold of 3.0
    send_idle_pct = 9;
    recv_idle_pct = 83;
    push_beat(32767, 1'b1);
    push_beat(-32768, 1'b0);
    push_beat(32767, 1'b1);
    repeat (2) push_beat(5, 1'b0);
    push_beat(5, 1'b1);
    repeat (10) push_beat(0, 1'b0);
    push_beat(30000, 1'b1);
    fill_random(15);
    drain_and_settle();

    write_threshold(16'd0);
    repeat (2) push_beat(-7, 1'b0);
    push_beat(-7, 1'b1);
    push_beat(-1, 1'b0);
    push_beat(1, 1'b1);
    fill_random(15);
    drain_and_settle();

    send_idle_pct = 83;
    recv_idle_pct = 9;
    write_threshold(16'hFFFF);
    fill_random(15);
    drain_and_settle();

    write_threshold(16'd256);
    fill_random(15);
    drain_and_settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(16'($urandom));
    fill_random(15);
    drain_and_settle();

    // store overflow, the closing sample is dropped too when the store is full
    write_threshold(16'd768);
    push_block($urandom_range(67, 65), 1'b1);
    fill_random(10);
    drain_and_settle();

    if (hit_queue.size() != 0) begin
      $error("%0d expected results never arrived", hit_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> zscore_anomaly_detector_core.f
rtl/core/zad_pkg.sv
rtl/core/zad_ram.sv
rtl/core/zad_fifo.sv
rtl/core/zad_front.sv
rtl/core/zad_back.sv
rtl/core/zscore_anomaly_detector_core.sv
tb/testbench.sv
